[hdl/bflru_pkg.sv]
// bflru_pkg: shared types and constants for the buffer frame lru table
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bflru_pkg;

    // fixed field widths
    localparam int FRAME_W = 8;
    localparam int PAGE_W  = 31;
    localparam int STAMP_W = 32;
    // table entry layout: {valid, page, stamp}
    localparam int ENTRY_W = 1 + PAGE_W + STAMP_W;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // action codes
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_ACCESS  = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic rd_entry;
        logic update;
        logic scan_step;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/bflru_ram.sv]
// bflru_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bflru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/bflru_ctrl.sv]
// bflru_ctrl: sequencing state machine for one request
// depends on bflru_pkg
`timescale 1ns / 1ps
`default_nettype none

module bflru_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire bflru_pkg::t_dp_stat i_stat,
    output bflru_pkg::t_dp_cmd      o_cmd,
    output logic                    busy,
    output logic                    o_valid
);

    bflru_pkg::t_state r_state;
    bflru_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bflru_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bflru_pkg::S_IDLE:   if (start) n_state = bflru_pkg::S_READ;
            bflru_pkg::S_READ:   n_state = bflru_pkg::S_UPDATE;
            bflru_pkg::S_UPDATE: n_state = bflru_pkg::S_SCAN;
            bflru_pkg::S_SCAN:   if (i_stat.scan_last) n_state = bflru_pkg::S_DRAIN;
            bflru_pkg::S_DRAIN:  n_state = bflru_pkg::S_DONE;
            bflru_pkg::S_DONE:   n_state = bflru_pkg::S_IDLE;
            default:             n_state = bflru_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            bflru_pkg::S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            bflru_pkg::S_READ:   o_cmd.rd_entry  = 1'b1;
            bflru_pkg::S_UPDATE: o_cmd.update    = 1'b1;
            bflru_pkg::S_SCAN:   o_cmd.scan_step = 1'b1;
            bflru_pkg::S_DRAIN:  o_cmd           = '0;
            bflru_pkg::S_DONE:   o_valid         = 1'b1;
            default:             o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/bflru_dp.sv]
// bflru_dp: frame table storage, update logic and sequential victim search
// depends on bflru_pkg and bflru_ram
`timescale 1ns / 1ps
`default_nettype none

module bflru_dp #(
    parameter int NUM_FRAMES = 16,
    parameter int AW         = 4,
    parameter int CW         = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bflru_pkg::t_dp_cmd                i_cmd,
    output bflru_pkg::t_dp_stat                    o_stat,
    input  wire logic [1:0]                        i_action,
    input  wire logic [bflru_pkg::FRAME_W-1:0]     i_frame_index,
    input  wire logic [bflru_pkg::PAGE_W-1:0]      i_page_id,
    output logic      [bflru_pkg::PAGE_W-1:0]      o_page_out,
    output logic                                   o_page_valid,
    output logic      [bflru_pkg::STAMP_W-1:0]     o_frame_stamp,
    output logic                                   o_range_error,
    output logic      [bflru_pkg::FRAME_W-1:0]     o_victim_index,
    output logic                                   o_victim_found,
    output logic      [bflru_pkg::STAMP_W-1:0]     o_oldest_stamp
);

    localparam int PW = bflru_pkg::PAGE_W;
    localparam int SW = bflru_pkg::STAMP_W;
    localparam int EW = bflru_pkg::ENTRY_W;

    // captured request
    logic [1:0]    r_action;
    logic [AW-1:0] r_frame;
    logic [PW-1:0] r_page;
    logic          r_in_range;

    // global use clock and per-frame written marks (unwritten reads as zero)
    logic [SW-1:0]         r_clock;
    logic [NUM_FRAMES-1:0] r_written;
    logic                  r_ent_wr;

    // scan state
    logic [CW-1:0] r_scan_addr;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    logic          r_pend_wr;
    logic          r_first;
    logic [AW-1:0] r_best_idx;
    logic [SW-1:0] r_best_stamp;

    // result registers
    logic [PW-1:0] r_res_page;
    logic          r_res_valid;
    logic [SW-1:0] r_res_stamp;
    logic          r_res_err;

    // ram ports
    logic          ram_wr_en;
    logic [EW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_data;

    // update logic
    logic          old_valid;
    logic [PW-1:0] old_page;
    logic [SW-1:0] old_stamp;
    logic [SW-1:0] clk_inc;
    logic          new_valid;
    logic [PW-1:0] new_page;
    logic [SW-1:0] new_stamp;
    logic [SW-1:0] n_clock;
    logic          do_write;
    logic [SW-1:0] pend_stamp;

    bflru_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_FRAMES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_frame),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // read address: addressed frame first, then the scan sweep
    assign ram_rd_en   = i_cmd.rd_entry | i_cmd.scan_step;
    assign ram_rd_addr = i_cmd.rd_entry ? r_frame : r_scan_addr[AW-1:0];

    // current entry of the addressed frame
    assign old_valid = r_ent_wr & ram_rd_data[EW-1];
    assign old_page  = r_ent_wr ? ram_rd_data[EW-2 -: PW] : '0;
    assign old_stamp = r_ent_wr ? ram_rd_data[SW-1:0] : '0;
    assign clk_inc   = (r_clock == bflru_pkg::STAMP_MAX) ? r_clock : r_clock + SW'(1);

    // new entry and clock per action
    always_comb begin
        new_valid = old_valid;
        new_page  = old_page;
        new_stamp = old_stamp;
        n_clock   = r_clock;
        do_write  = 1'b0;
        unique case (r_action)
            bflru_pkg::ACT_LOAD: begin
                new_valid = 1'b1;
                new_page  = r_page;
                new_stamp = clk_inc;
                n_clock   = clk_inc;
                do_write  = 1'b1;
            end
            bflru_pkg::ACT_ACCESS: begin
                new_stamp = clk_inc;
                n_clock   = clk_inc;
                do_write  = 1'b1;
            end
            bflru_pkg::ACT_RELEASE: begin
                new_valid = 1'b0;
                new_page  = '0;
                new_stamp = '0;
                do_write  = 1'b1;
            end
            default: do_write = 1'b0;
        endcase
    end

    assign ram_wr_en   = i_cmd.update & r_in_range & do_write;
    assign ram_wr_data = {new_valid, new_page, new_stamp};

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_action;
            r_frame    <= i_frame_index[AW-1:0];
            r_page     <= i_page_id;
            r_in_range <= {1'b0, i_frame_index} < (bflru_pkg::FRAME_W+1)'(NUM_FRAMES);
        end
    end

    // clock and written marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock   <= '0;
            r_written <= '0;
        end else if (i_cmd.update && r_in_range) begin
            r_clock <= n_clock;
            if (do_write) begin
                r_written[r_frame] <= 1'b1;
            end
        end
    end

    // addressed entry result
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_entry) begin
            r_ent_wr <= r_written[r_frame];
        end
        if (i_cmd.update) begin
            r_res_err   <= ~r_in_range;
            r_res_valid <= r_in_range & new_valid;
            r_res_page  <= r_in_range ? new_page : '0;
            r_res_stamp <= r_in_range ? new_stamp : '0;
        end
    end

    // scan address counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + CW'(1);
        end
    end

    assign o_stat.scan_last = (r_scan_addr == CW'(NUM_FRAMES - 1));

    // read pending marker, registered from the scan step so it trails the scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_pend_idx <= r_scan_addr[AW-1:0];
            r_pend_wr  <= r_written[r_scan_addr[AW-1:0]];
        end
    end

    assign pend_stamp = r_pend_wr ? ram_rd_data[SW-1:0] : '0;

    // running minimum, strict compare keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_first <= 1'b1;
        end else if (r_pend) begin
            r_first <= 1'b0;
            if (r_first || (pend_stamp < r_best_stamp)) begin
                r_best_idx   <= r_pend_idx;
                r_best_stamp <= pend_stamp;
            end
        end
    end

    assign o_page_out     = r_res_page;
    assign o_page_valid   = r_res_valid;
    assign o_frame_stamp  = r_res_stamp;
    assign o_range_error  = r_res_err;
    assign o_victim_index = bflru_pkg::FRAME_W'(r_best_idx);
    assign o_victim_found = 1'b1;
    assign o_oldest_stamp = r_best_stamp;

endmodule

`default_nettype wire

[hdl/buffer_frame_lru_table_unit.sv]
// buffer_frame_lru_table_unit: top level of the lru buffer frame table
// depends on bflru_pkg, bflru_ctrl, bflru_dp and bflru_ram
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high while busy is low. The addressed
// frame is read and then updated, then the victim search reads every frame
// stamp from the table ram, one per cycle, followed by a drain state. Busy
// stays high until the result has been shown, so a new request is taken
// only after the previous one has finished. The result is shown for exactly
// one cycle with o_valid high; the receiver cannot stall it and must take it
// in that cycle. The table holds no per-frame reset sweep: frames never
// written read as empty with stamp zero right after reset.

module buffer_frame_lru_table_unit #(
    parameter int NUM_FRAMES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_frame_index,
    input  wire logic [30:0] i_page_id,
    output logic             o_valid,
    output logic [30:0]      o_page_out,
    output logic             o_page_valid,
    output logic [31:0]      o_frame_stamp,
    output logic             o_range_error,
    output logic [7:0]       o_victim_index,
    output logic             o_victim_found,
    output logic [31:0]      o_oldest_stamp
);

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = AW + 1;

    bflru_pkg::t_dp_cmd  cmd;
    bflru_pkg::t_dp_stat stat;

    // sequencer
    bflru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // table and search datapath
    bflru_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .AW         (AW),
        .CW         (CW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_action),
        .i_frame_index  (i_frame_index),
        .i_page_id      (i_page_id),
        .o_page_out     (o_page_out),
        .o_page_valid   (o_page_valid),
        .o_frame_stamp  (o_frame_stamp),
        .o_range_error  (o_range_error),
        .o_victim_index (o_victim_index),
        .o_victim_found (o_victim_found),
        .o_oldest_stamp (o_oldest_stamp)
    );

endmodule

`default_nettype wire

[hdl/bflru_checker.sv]
// bflru_checker: port-level assertions for the lru buffer frame table
// bound to buffer_frame_lru_table_unit; no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module bflru_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [30:0] o_page_out,
    input wire logic        o_page_valid,
    input wire logic [31:0] o_frame_stamp,
    input wire logic        o_range_error,
    input wire logic [31:0] o_oldest_stamp
);

    // a transfer in makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // a result only shows while its request is still in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a request");

    // one result per request, never on consecutive cycles
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // rejected frame index reports an empty frame
    a_range_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |->
            (!o_page_valid && (o_page_out == 31'd0) && (o_frame_stamp == 32'd0)))
        else $error("range error with frame contents");

    // the oldest stamp never exceeds the addressed frame's stamp
    a_oldest_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_range_error) |-> (o_oldest_stamp <= o_frame_stamp))
        else $error("oldest stamp above addressed frame stamp");

endmodule

bind buffer_frame_lru_table_unit bflru_checker u_bflru_checker (.*);

`default_nettype wire
